// ===== hw/rtl/word_frequency_counter_assert.svh =====
// assertion helpers for the word frequency counter
`ifndef WORD_FREQUENCY_COUNTER_ASSERT_SVH
`define WORD_FREQUENCY_COUNTER_ASSERT_SVH

// condition holds at every edge out of reset
`define WFC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// condition in the cycle after a trigger
`define WFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/wfc_pkg.sv =====
`default_nettype none
package wfc_pkg;

  localparam int CNT_BITS = 24;
  localparam int RANK_W   = 12;

  localparam logic [1:0] MODE_TEXT   = 2'd0;
  localparam logic [1:0] MODE_FINISH = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  localparam logic [CNT_BITS-1:0] COUNT_MAX = {CNT_BITS{1'b1}};

  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        text_byte;
    logic [RANK_W-1:0] rank;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          word_char;
    logic [5:0]          word_length;
    logic [CNT_BITS-1:0] occurrences;
    logic                rank_valid;
    logic                table_overflowed;
    logic                last;
  } out_item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wfc_ram.sv =====
`default_nettype none
module wfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/word_frequency_counter.sv =====
`default_nettype none
// Word frequency counter.
// Input channel (in_valid/in_stall/in_item): mode 0 feeds one text byte, mode 1
// ends the text and sorts the table by count, mode 2 asks for the word at a
// rank. Mode 3 is taken and ignored.
// Output channel (out_valid/out_stall/out_item): a query returns one item per
// byte of the ranked word, last set on the final one; a rank beyond the used
// entries returns a single item with zero word fields, rank_valid clear and last set.
// A word end scans the stored words one per cycle out of the word row memory.
// Finish adds a merge sort over the rank order memory: it seeds the identity
// order, then each pass takes every entry through order read, count read,
// compare and write, with ceil(log2(used)) passes. A query reads the order
// entry, then the row and count, and then emits one byte per cycle while
// out_stall is low.
// Reset clears the used count, the pending word and the overflow flag; the
// memories need no clearing. While out_stall is high the output register
// holds its item and the byte stream pauses.
module word_frequency_counter #(
  parameter int TABLE_DEPTH = 4096,
  parameter int WORD_LEN    = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wfc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output wfc_pkg::out_item_t out_item
);
  import wfc_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int SW     = CNT_W + 2;
  localparam int LEN_W  = $clog2(WORD_LEN + 1);
  localparam int PIDX_W = (WORD_LEN > 1) ? $clog2(WORD_LEN) : 1;
  localparam int ROW_W  = 8 * WORD_LEN;
  localparam int META_W = LEN_W + CNT_BITS;
  localparam int CW     = (CNT_W > RANK_W) ? CNT_W : RANK_W;
  localparam int ORD_AW = IDX_W + 1;
  localparam int ORD_DEPTH = 2 ** ORD_AW;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SRCH  = 4'd1;
  localparam logic [3:0] ST_QENT  = 4'd2;
  localparam logic [3:0] ST_QROW  = 4'd3;
  localparam logic [3:0] ST_QEMIT = 4'd4;
  localparam logic [3:0] ST_INIT  = 4'd5;
  localparam logic [3:0] ST_BLK   = 4'd6;
  localparam logic [3:0] ST_BLK2  = 4'd7;
  localparam logic [3:0] ST_F0    = 4'd8;
  localparam logic [3:0] ST_F1    = 4'd9;
  localparam logic [3:0] ST_F2    = 4'd10;
  localparam logic [3:0] ST_OUT   = 4'd11;

  // control registers
  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic             ovf_r, ovf_nxt;
  logic [LEN_W-1:0] pend_len_r, pend_len_nxt;
  logic             sel_r, sel_nxt;
  logic             fin_r, fin_nxt;
  logic [CNT_W-1:0] ctr_r, ctr_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             q_bad_r, q_bad_nxt;
  logic [LEN_W-1:0] q_k_r, q_k_nxt;
  logic [LEN_W-1:0] q_len_r, q_len_nxt;
  logic [CNT_BITS-1:0] q_cnt_r, q_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  // sort registers
  logic [SW-1:0]       w_r, w_nxt, lo_r, lo_nxt, mid_r, mid_nxt, hi_r, hi_nxt;
  logic [SW-1:0]       p_r, p_nxt, q_r, q_nxt, k_r, k_nxt;
  logic                side_r, side_nxt, init_q_r, init_q_nxt;
  logic [IDX_W-1:0]    pidx_r, pidx_nxt, qidx_r, qidx_nxt, tidx_r, tidx_nxt;
  logic [CNT_BITS-1:0] pcnt_r, pcnt_nxt, qcnt_r, qcnt_nxt;

  // pending word and fetched row
  logic [7:0] pend_r [WORD_LEN];
  logic [7:0] row_r  [WORD_LEN];
  logic       pend_we, row_ld;
  logic [7:0] pend_byte;

  // memory ports
  logic              row_we;
  logic [IDX_W-1:0]  row_waddr, row_raddr;
  logic [ROW_W-1:0]  row_rdata;
  logic              meta_we;
  logic [IDX_W-1:0]  meta_waddr, meta_raddr;
  logic [META_W-1:0] meta_wdata, meta_rdata;
  logic              ord_we;
  logic [ORD_AW-1:0] ord_waddr, ord_raddr;
  logic [IDX_W-1:0]  ord_wdata, ord_rdata;

  logic [ROW_W-1:0]    key;
  logic [LEN_W-1:0]    meta_len;
  logic [CNT_BITS-1:0] meta_cnt;
  logic                hit, start_sort, out_free, take_q, blk_end, fetch_done;
  logic [SW-1:0]       n_ext, f_ptr, f_end, lo_step, w_dbl, sum_a;

  assign meta_len = meta_rdata[META_W-1:CNT_BITS];
  assign meta_cnt = meta_rdata[CNT_BITS-1:0];
  assign n_ext    = SW'(used_r);
  assign out_free = !out_valid_r || !out_stall;

  // pending word with stale bytes past its length cleared
  always_comb begin
    for (int b = 0; b < WORD_LEN; b++) begin
      key[b*8 +: 8] = (LEN_W'(b) < pend_len_r) ? pend_r[b] : 8'd0;
    end
  end

  wfc_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_DEPTH)) u_rows (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(key),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  wfc_ram #(.WIDTH(META_W), .DEPTH(TABLE_DEPTH)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rdata)
  );

  // two banks of rank order, sel_r marks the live one
  wfc_ram #(.WIDTH(IDX_W), .DEPTH(ORD_DEPTH)) u_order (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );

  // main sequencer
  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    ovf_nxt      = ovf_r;
    pend_len_nxt = pend_len_r;
    sel_nxt      = sel_r;
    fin_nxt      = fin_r;
    ctr_nxt      = ctr_r;
    cmp_vld_nxt  = cmp_vld_r;
    cmp_idx_nxt  = cmp_idx_r;
    q_bad_nxt    = q_bad_r;
    q_k_nxt      = q_k_r;
    q_len_nxt    = q_len_r;
    q_cnt_nxt    = q_cnt_r;
    w_nxt        = w_r;
    lo_nxt       = lo_r;
    mid_nxt      = mid_r;
    hi_nxt       = hi_r;
    p_nxt        = p_r;
    q_nxt        = q_r;
    k_nxt        = k_r;
    side_nxt     = side_r;
    init_q_nxt   = init_q_r;
    pidx_nxt     = pidx_r;
    qidx_nxt     = qidx_r;
    tidx_nxt     = tidx_r;
    pcnt_nxt     = pcnt_r;
    qcnt_nxt     = qcnt_r;
    out_item_nxt = out_item_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    pend_we      = 1'b0;
    pend_byte    = in_item.text_byte;
    row_ld       = 1'b0;
    row_we       = 1'b0;
    row_waddr    = used_r[IDX_W-1:0];
    row_raddr    = ctr_r[IDX_W-1:0];
    meta_we      = 1'b0;
    meta_waddr   = used_r[IDX_W-1:0];
    meta_wdata   = {pend_len_r, CNT_BITS'(1)};
    meta_raddr   = ctr_r[IDX_W-1:0];
    ord_we       = 1'b0;
    ord_waddr    = {sel_r, used_r[IDX_W-1:0]};
    ord_wdata    = used_r[IDX_W-1:0];
    ord_raddr    = {sel_r, IDX_W'(in_item.rank)};
    start_sort   = 1'b0;
    hit          = 1'b0;
    take_q       = 1'b0;
    blk_end      = 1'b0;
    fetch_done   = 1'b0;
    f_ptr        = side_r ? q_r : p_r;
    f_end        = side_r ? hi_r : mid_r;
    lo_step      = lo_r + (w_r << 1);
    w_dbl        = w_r << 1;
    sum_a        = lo_r + w_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_item.mode)
            MODE_TEXT: begin
              if (in_item.text_byte inside {8'd32, [8'd9:8'd13]}) begin
                if (pend_len_r != '0) begin
                  state_nxt   = ST_SRCH;
                  ctr_nxt     = '0;
                  cmp_vld_nxt = 1'b0;
                  fin_nxt     = 1'b0;
                end
              end else if (pend_len_r < LEN_W'(WORD_LEN)) begin
                pend_we = 1'b1;
                if (in_item.text_byte inside {[8'd65:8'd90]}) begin
                  pend_byte = in_item.text_byte + 8'd32;
                end
                pend_len_nxt = pend_len_r + LEN_W'(1);
              end
            end
            MODE_FINISH: begin
              if (pend_len_r != '0) begin
                state_nxt   = ST_SRCH;
                ctr_nxt     = '0;
                cmp_vld_nxt = 1'b0;
                fin_nxt     = 1'b1;
              end else begin
                start_sort = 1'b1;
              end
            end
            MODE_QUERY: begin
              q_k_nxt = '0;
              if (CW'(in_item.rank) < CW'(used_r)) begin
                q_bad_nxt = 1'b0;
                state_nxt = ST_QENT;
              end else begin
                q_bad_nxt = 1'b1;
                state_nxt = ST_QEMIT;
              end
            end
            default: ;
          endcase
        end
      end

      // linear scan, one entry per cycle, compare in the cycle after the read
      ST_SRCH: begin
        hit = cmp_vld_r && (meta_len == pend_len_r) && (row_rdata == key);
        if (hit) begin
          meta_we    = 1'b1;
          meta_waddr = cmp_idx_r;
          meta_wdata = {meta_len, (meta_cnt == COUNT_MAX) ? meta_cnt
                                                          : meta_cnt + CNT_BITS'(1)};
          pend_len_nxt = '0;
          if (fin_r) start_sort = 1'b1;
          else state_nxt = ST_IDLE;
        end else if (ctr_r < used_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = ctr_r[IDX_W-1:0];
          ctr_nxt     = ctr_r + CNT_W'(1);
        end else if (!cmp_vld_r) begin
          // no match: append or drop
          if (used_r < CNT_W'(TABLE_DEPTH)) begin
            row_we   = 1'b1;
            meta_we  = 1'b1;
            ord_we   = 1'b1;
            used_nxt = used_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          pend_len_nxt = '0;
          if (fin_r) start_sort = 1'b1;
          else state_nxt = ST_IDLE;
        end else begin
          cmp_vld_nxt = 1'b0;
        end
      end

      // query: order entry read, then row and count read
      ST_QENT: begin
        row_raddr  = ord_rdata;
        meta_raddr = ord_rdata;
        state_nxt  = ST_QROW;
      end

      ST_QROW: begin
        row_ld    = 1'b1;
        q_len_nxt = meta_len;
        q_cnt_nxt = meta_cnt;
        state_nxt = ST_QEMIT;
      end

      ST_QEMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt.table_overflowed = ovf_r;
          if (q_bad_r) begin
            out_item_nxt.word_char   = 8'd0;
            out_item_nxt.word_length = 6'd0;
            out_item_nxt.occurrences = '0;
            out_item_nxt.rank_valid  = 1'b0;
            out_item_nxt.last        = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            out_item_nxt.word_char   = row_r[q_k_r[PIDX_W-1:0]];
            out_item_nxt.word_length = 6'(q_len_r);
            out_item_nxt.occurrences = q_cnt_r;
            out_item_nxt.rank_valid  = 1'b1;
            out_item_nxt.last        = (q_k_r + LEN_W'(1)) == q_len_r;
            if ((q_k_r + LEN_W'(1)) == q_len_r) state_nxt = ST_IDLE;
            else q_k_nxt = q_k_r + LEN_W'(1);
          end
        end
      end

      // seed identity order
      ST_INIT: begin
        ord_we    = 1'b1;
        ord_waddr = {sel_r, ctr_r[IDX_W-1:0]};
        ord_wdata = ctr_r[IDX_W-1:0];
        ctr_nxt   = ctr_r + CNT_W'(1);
        if ((ctr_r + CNT_W'(1)) == used_r) begin
          w_nxt     = SW'(1);
          lo_nxt    = '0;
          state_nxt = ST_BLK;
        end
      end

      ST_BLK: begin
        mid_nxt   = (sum_a < n_ext) ? sum_a : n_ext;
        p_nxt     = lo_r;
        k_nxt     = lo_r;
        state_nxt = ST_BLK2;
      end

      ST_BLK2: begin
        hi_nxt     = ((mid_r + w_r) < n_ext) ? (mid_r + w_r) : n_ext;
        q_nxt      = mid_r;
        side_nxt   = 1'b0;
        init_q_nxt = 1'b1;
        state_nxt  = ST_F0;
      end

      // fetch head of one run: order entry, then its count
      ST_F0: begin
        if (f_ptr < f_end) begin
          ord_raddr = {sel_r, f_ptr[IDX_W-1:0]};
          state_nxt = ST_F1;
        end else begin
          fetch_done = 1'b1;
        end
      end

      ST_F1: begin
        tidx_nxt   = ord_rdata;
        meta_raddr = ord_rdata;
        state_nxt  = ST_F2;
      end

      ST_F2: begin
        if (side_r) begin
          qidx_nxt = tidx_r;
          qcnt_nxt = meta_cnt;
        end else begin
          pidx_nxt = tidx_r;
          pcnt_nxt = meta_cnt;
        end
        fetch_done = 1'b1;
      end

      // merge step: higher count first, earlier entry on a tie
      ST_OUT: begin
        take_q = (q_r < hi_r) &&
                 (!(p_r < mid_r) || (qcnt_r > pcnt_r) ||
                  ((qcnt_r == pcnt_r) && (qidx_r < pidx_r)));
        ord_we    = 1'b1;
        ord_waddr = {!sel_r, k_r[IDX_W-1:0]};
        ord_wdata = take_q ? qidx_r : pidx_r;
        k_nxt     = k_r + SW'(1);
        side_nxt  = take_q;
        if (take_q) q_nxt = q_r + SW'(1);
        else p_nxt = p_r + SW'(1);
        blk_end = (k_r + SW'(1)) == hi_r;
        if (!blk_end) begin
          state_nxt = ST_F0;
        end else if (lo_step < n_ext) begin
          lo_nxt    = lo_step;
          state_nxt = ST_BLK;
        end else begin
          sel_nxt = !sel_r;
          w_nxt   = w_dbl;
          lo_nxt  = '0;
          if (w_dbl < n_ext) state_nxt = ST_BLK;
          else state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // after a fetch, fetch the second run once at block start
    if (fetch_done) begin
      if (!side_r && init_q_r) begin
        side_nxt   = 1'b1;
        init_q_nxt = 1'b0;
        state_nxt  = ST_F0;
      end else begin
        state_nxt = ST_OUT;
      end
    end

    // sort launch
    if (start_sort) begin
      ctr_nxt = '0;
      if (used_nxt <= CNT_W'(1)) state_nxt = ST_IDLE;
      else state_nxt = ST_INIT;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      pend_len_r  <= '0;
      sel_r       <= 1'b0;
      fin_r       <= 1'b0;
      ctr_r       <= '0;
      cmp_vld_r   <= 1'b0;
      q_bad_r     <= 1'b0;
      q_k_r       <= '0;
      side_r      <= 1'b0;
      init_q_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      ovf_r       <= ovf_nxt;
      pend_len_r  <= pend_len_nxt;
      sel_r       <= sel_nxt;
      fin_r       <= fin_nxt;
      ctr_r       <= ctr_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      q_bad_r     <= q_bad_nxt;
      q_k_r       <= q_k_nxt;
      side_r      <= side_nxt;
      init_q_r    <= init_q_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    cmp_idx_r  <= cmp_idx_nxt;
    q_len_r    <= q_len_nxt;
    q_cnt_r    <= q_cnt_nxt;
    w_r        <= w_nxt;
    lo_r       <= lo_nxt;
    mid_r      <= mid_nxt;
    hi_r       <= hi_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    k_r        <= k_nxt;
    pidx_r     <= pidx_nxt;
    qidx_r     <= qidx_nxt;
    tidx_r     <= tidx_nxt;
    pcnt_r     <= pcnt_nxt;
    qcnt_r     <= qcnt_nxt;
    out_item_r <= out_item_nxt;
    if (pend_we) begin
      pend_r[pend_len_r[PIDX_W-1:0]] <= pend_byte;
    end
    if (row_ld) begin
      for (int b = 0; b < WORD_LEN; b++) begin
        row_r[b] <= row_rdata[b*8 +: 8];
      end
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`include "word_frequency_counter_assert.svh"

  `WFC_ASSERT_ALWAYS(a_used_bound, used_r <= CNT_W'(TABLE_DEPTH), "used count past table depth")
  `WFC_ASSERT_ALWAYS(a_pend_bound, pend_len_r <= LEN_W'(WORD_LEN), "pending word too long")
  `WFC_ASSERT_NEXT(a_ovf_sticky, ovf_r, ovf_r, "overflow flag dropped")
  `WFC_ASSERT_ALWAYS(a_srch_word, (state_r != ST_SRCH) || (pend_len_r != '0), "scan without word")

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import wfc_pkg::*;

  localparam int DEPTH      = 16;
  localparam int WLEN       = 32;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // reference of the counter: word table, rank order and expected bytes
  class word_count_scoreboard;
    byte unsigned word_text[DEPTH][WLEN];
    int           word_len[DEPTH];
    logic [23:0]  word_cnt[DEPTH];
    int           rank_map[DEPTH];
    int           used;
    byte unsigned pend_text[WLEN];
    int           pend_len;
    bit           overflow;
    out_item_t    expected_q[$];
    int           errors;

    function new();
      used = 0;
      pend_len = 0;
      overflow = 0;
      errors = 0;
    endfunction

    // end of word: bump a match, append a new word or flag overflow
    function void flush_pending();
      int len;
      bit same;
      len = pend_len;
      if (len == 0) return;
      pend_len = 0;
      for (int i = 0; i < used; i++) begin
        same = (word_len[i] == len);
        for (int k = 0; k < len && same; k++)
          if (word_text[i][k] != pend_text[k]) same = 0;
        if (same) begin
          if (word_cnt[i] != COUNT_MAX) word_cnt[i]++;
          return;
        end
      end
      if (used < DEPTH) begin
        for (int k = 0; k < len; k++) word_text[used][k] = pend_text[k];
        word_len[used] = len;
        word_cnt[used] = 24'd1;
        rank_map[used] = used;
        used++;
      end else begin
        overflow = 1;
      end
    endfunction

    // higher count first, ties by first appearance
    function void sort_by_count();
      int key;
      int j;
      for (int i = 0; i < used; i++) rank_map[i] = i;
      for (int i = 1; i < used; i++) begin
        key = rank_map[i];
        j = i - 1;
        while (j >= 0 && (word_cnt[key] > word_cnt[rank_map[j]] ||
               (word_cnt[key] == word_cnt[rank_map[j]] && key < rank_map[j]))) begin
          rank_map[j+1] = rank_map[j];
          j--;
        end
        rank_map[j+1] = key;
      end
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      byte unsigned b;
      int e;
      case (it.mode)
        MODE_TEXT: begin
          b = it.text_byte;
          if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
            flush_pending();
          end else if (pend_len < WLEN) begin
            if (b >= 8'h41 && b <= 8'h5A) b = b + 8'h20;
            pend_text[pend_len] = b;
            pend_len++;
          end
        end
        MODE_FINISH: begin
          flush_pending();
          sort_by_count();
        end
        MODE_QUERY: begin
          if (it.rank < used) begin
            e = rank_map[it.rank];
            for (int k = 0; k < word_len[e]; k++) begin
              r.word_char        = word_text[e][k];
              r.word_length      = 6'(word_len[e]);
              r.occurrences      = word_cnt[e];
              r.rank_valid       = 1'b1;
              r.table_overflowed = overflow;
              r.last             = (k == word_len[e] - 1);
              expected_q.push_back(r);
            end
          end else begin
            r = '0;
            r.table_overflowed = overflow;
            r.last = 1'b1;
            expected_q.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    function void field_mismatch(string name, longint unsigned exp_v, longint unsigned act_v);
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.word_char !== exp_r.word_char)
        field_mismatch("word_char", exp_r.word_char, got.word_char);
      if (got.word_length !== exp_r.word_length)
        field_mismatch("word_length", exp_r.word_length, got.word_length);
      if (got.occurrences !== exp_r.occurrences)
        field_mismatch("occurrences", exp_r.occurrences, got.occurrences);
      if (got.rank_valid !== exp_r.rank_valid)
        field_mismatch("rank_valid", exp_r.rank_valid, got.rank_valid);
      if (got.table_overflowed !== exp_r.table_overflowed)
        field_mismatch("table_overflowed", exp_r.table_overflowed, got.table_overflowed);
      if (got.last !== exp_r.last)
        field_mismatch("last", exp_r.last, got.last);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  word_count_scoreboard sb = new();
  bit send_quiet;
  bit recv_quiet;
  bit long_hold;
  bit hold_done;
  int idle_cycles;
  int item_count;

  word_frequency_counter #(.TABLE_DEPTH(DEPTH), .WORD_LEN(WLEN)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[word_frequency_counter] ERROR");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold on request
  initial begin
    int n;
    out_stall = 0;
    forever begin
      if (long_hold) begin
        out_stall <= 1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 0;
      end
      n = recv_quiet ? 0 : $urandom_range(0, 17);
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_item);
      @(negedge clk);
    end
  end

  // one item on the input channel, called at a falling edge
  task automatic send_item(in_item_t it);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    if (it.mode != MODE_UNUSED) item_count++;
    @(negedge clk);
  endtask

  task automatic send_text(byte unsigned b);
    in_item_t it;
    it = in_item_t'($urandom);
    it.mode = MODE_TEXT;
    it.text_byte = b;
    send_item(it);
  endtask

  task automatic send_cmd(logic [1:0] m, logic [11:0] r);
    in_item_t it;
    it = in_item_t'($urandom);
    it.mode = m;
    it.rank = r;
    send_item(it);
  endtask

  task automatic send_separator();
    byte unsigned seps[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    send_text(seps[$urandom_range(0, 5)]);
  endtask

  // word drawn from a vocabulary larger than the table, mixed case
  task automatic send_word(int v, bit too_long);
    int len;
    byte unsigned c;
    len = too_long ? 40 : 1 + v % 5;
    for (int k = 0; k < len; k++) begin
      c = 8'h61 + 8'((v * 7 + k * 3) % 26);
      if ($urandom_range(0, 1)) c = c - 8'h20;
      if ($urandom_range(0, 19) == 0) c = 8'h80 | 8'($urandom);
      send_text(c);
    end
    send_separator();
    if ($urandom_range(0, 3) == 0) send_separator();
  endtask

  initial begin
    int pick;
    rst_n = 0;
    in_valid = 0;
    in_item = '0;
    idle_cycles = 0;
    item_count = 0;
    send_quiet = 0;
    recv_quiet = 0;
    long_hold = 0;
    hold_done = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: empty table, odd bytes, case folding edges, bad ranks
    send_cmd(MODE_FINISH, '0);
    send_cmd(MODE_QUERY, 12'd0);
    send_text(8'h00);
    send_text(8'hFF);
    send_text(8'h41);
    send_text(8'h5A);
    send_text(8'h40);
    send_text(8'h5B);
    send_text(8'h20);
    send_text(8'h09);
    send_text(8'h61);
    send_text(8'h7A);
    send_text(8'h60);
    send_text(8'h7B);
    send_text(8'h0D);
    send_text(8'h41);
    send_cmd(MODE_UNUSED, 12'hFFF);
    send_cmd(MODE_QUERY, 12'd1);
    send_cmd(MODE_FINISH, '0);
    send_cmd(MODE_QUERY, 12'd0);
    send_cmd(MODE_QUERY, 12'd1);
    send_cmd(MODE_QUERY, 12'd2);
    send_cmd(MODE_QUERY, 12'hFFF);

    // random text with finishes, queries and noise
    send_word(3, 1);
    send_word(3, 1);
    while (item_count < 140) begin
      if (item_count > 112 && item_count < 120) begin
        send_quiet = 1;
        recv_quiet = 1;
      end else if (item_count > 128 && item_count < 136) begin
        send_quiet = 0;
        recv_quiet = 1;
      end else begin
        send_quiet = 0;
        recv_quiet = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_word($urandom_range(0, 23), 0);
      end else if (pick < 72) begin
        send_text(8'($urandom));
      end else if (pick < 75) begin
        send_cmd(MODE_UNUSED, 12'($urandom));
      end else if (pick < 82) begin
        send_cmd(MODE_FINISH, 12'($urandom));
      end else if (pick < 95) begin
        send_cmd(MODE_QUERY, 12'($urandom_range(0, DEPTH + 1)));
      end else begin
        send_cmd(MODE_QUERY, 12'($urandom));
      end
      if (item_count > 110 && !hold_done) begin
        // long receiver hold while queries keep coming
        hold_done = 1;
        long_hold = 1;
        send_quiet = 1;
        for (int r = 0; r < 8; r++) send_cmd(MODE_QUERY, 12'(r));
        send_quiet = 0;
        // then a pause until every byte is back
        in_valid <= 0;
        while (sb.expected_q.size() != 0) @(negedge clk);
      end
    end
    send_cmd(MODE_FINISH, '0);
    for (int r = 0; r <= DEPTH; r++) send_cmd(MODE_QUERY, 12'(r));
    in_valid <= 0;

    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[word_frequency_counter] OK");
    end else begin
      $display("[word_frequency_counter] ERROR");
    end
    $finish;
  end

endmodule
